/* sv/lsx_pkg.sv */
package lsx_pkg;

	// command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_EXEC  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// register file indexes
	localparam logic [2:0] IX_A = 3'd0;
	localparam logic [2:0] IX_F = 3'd1;
	localparam logic [2:0] IX_B = 3'd2;
	localparam logic [2:0] IX_C = 3'd3;
	localparam logic [2:0] IX_D = 3'd4;
	localparam logic [2:0] IX_E = 3'd5;
	localparam logic [2:0] IX_H = 3'd6;
	localparam logic [2:0] IX_L = 3'd7;

	localparam logic [15:0] HIGH_PAGE = 16'hFF00;

	// input and result words
	typedef struct packed {
		logic [7:0]  mem_wdata;
		logic [15:0] mem_addr;
		logic [1:0]  cmd;
	} in_word_t;

	typedef struct packed {
		logic        status;
		logic [7:0]  read_data;
		logic [2:0]  machine_cycles;
		logic [15:0] prog_ctr;
		logic [15:0] stack_ptr;
		logic [15:0] pair_hl;
		logic [15:0] pair_de;
		logic [15:0] pair_bc;
		logic [7:0]  reg_f;
		logic [7:0]  reg_a;
	} out_word_t;

	// r8 operand code to register index; (HL) code 6 handled separately
	function automatic logic [2:0] r8_index(input logic [2:0] code);
		logic [2:0] r;
		case (code)
			3'd0: r = IX_B;
			3'd1: r = IX_C;
			3'd2: r = IX_D;
			3'd3: r = IX_E;
			3'd4: r = IX_H;
			3'd5: r = IX_L;
			3'd7: r = IX_A;
			default: r = IX_A;
		endcase
		return r;
	endfunction

endpackage

/* sv/lsx_ram.sv */
module lsx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* sv/cpu_load_store_execute.sv */
// From the accepted input word to a valid result, each memory read passes through
// ST_RDREQ, ST_RDWT and ST_RDGOT and each memory write through ST_RDREQ; execute
// adds a further decode pass for a two-byte immediate or LD HL,SP+e.
// Throughput: one word at a time; the next word is taken on the cycle after the
// result is taken, and the single byte memory port sets the pace.
// Reset (arst_n low): registers A..L, SP and PC clear to zero; the byte memory
// is not cleared and holds no defined value until written.
module cpu_load_store_execute #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // cmd[1:0], mem_addr[17:2], mem_wdata[25:18], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [111:0] m_tdata  // reg_a, reg_f, pair_bc, pair_de, pair_hl,
	                              // stack_ptr, prog_ctr, machine_cycles,
	                              // read_data, status (low to high), zero
);
	import lsx_pkg::*;

	localparam int AW = MEM_ADDR_BITS;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RDREQ = 3'd1;
	localparam logic [2:0] ST_RDWT  = 3'd2;
	localparam logic [2:0] ST_RDGOT = 3'd3;
	localparam logic [2:0] ST_DEC   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	// micro steps after decode
	localparam logic [3:0] K_FETCH   = 4'd0;  // fetch op
	localparam logic [3:0] K_OP      = 4'd1;  // have op
	localparam logic [3:0] K_IMM1    = 4'd2;  // have first immediate
	localparam logic [3:0] K_IMM2    = 4'd3;  // have second immediate
	localparam logic [3:0] K_DATA    = 4'd4;  // have loaded data
	localparam logic [3:0] K_DATA2   = 4'd5;  // have second loaded data
	localparam logic [3:0] K_WR2     = 4'd6;  // second write pending
	localparam logic [3:0] K_MEMCMD  = 4'd7;  // plain memory command

	in_word_t  in_w;
	out_word_t res_q;
	assign in_w = in_word_t'(s_tdata[25:0]);

	logic [2:0]  st_q;
	logic [3:0]  k_q;
	logic [7:0]  rf_q [8];
	logic [15:0] sp_q, pc_q;
	logic [7:0]  op_q, b1_q, b2_q;
	logic [15:0] ad_q;
	logic [1:0]  cmd_q;
	logic [7:0]  wd_q;
	logic        out_v_q;
	logic [2:0]  cyc_q;
	logic [7:0]  rd_q;
	logic        err_q;

	// memory port
	logic          m_we;
	logic [AW-1:0] m_addr;
	logic [7:0]    m_wd, m_rd;

	lsx_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_mem (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
	);

	// pending access, set by decode
	logic          acc_wr_q;
	logic [15:0]   acc_a_q;
	logic [7:0]    acc_d_q;

	assign m_we   = (st_q == ST_RDREQ) && acc_wr_q;
	assign m_addr = acc_a_q[AW-1:0];
	assign m_wd   = acc_d_q;

	assign s_tready = (st_q == ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, res_q};

	wire [15:0] hl = {rf_q[IX_H], rf_q[IX_L]};
	wire [15:0] bc = {rf_q[IX_B], rf_q[IX_C]};
	wire [15:0] de = {rf_q[IX_D], rf_q[IX_E]};
	wire [15:0] imm16 = {b2_q, b1_q};
	wire [2:0]  r_dst = r8_index(op_q[5:3]);
	wire [2:0]  r_src = r8_index(op_q[2:0]);
	wire        is_ldrr = (op_q[7:6] == 2'b01) && (op_q != 8'h76);
	// PUSH/POP pair high register
	wire [2:0]  pp_hi = (op_q[5:4] == 2'd3) ? IX_A :
	                    (op_q[5:4] == 2'd0) ? IX_B :
	                    (op_q[5:4] == 2'd1) ? IX_D : IX_H;
	wire [2:0]  pp_lo = pp_hi + 3'd1;
	wire [4:0]  hsum = {1'b0, sp_q[3:0]} + {1'b0, b1_q[3:0]};
	wire [8:0]  csum = {1'b0, sp_q[7:0]} + {1'b0, b1_q};
	wire [15:0] spe  = sp_q + {{8{b1_q[7]}}, b1_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			k_q <= K_FETCH;
			for (int i = 0; i < 8; i++) rf_q[i] <= '0;
			sp_q <= '0;
			pc_q <= '0;
			out_v_q <= 1'b0;
			acc_wr_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						cmd_q <= in_w.cmd;
						ad_q <= in_w.mem_addr;
						wd_q <= in_w.mem_wdata;
						cyc_q <= '0;
						rd_q <= '0;
						err_q <= 1'b0;
						st_q <= ST_DEC;
						k_q <= (in_w.cmd == CMD_EXEC) ? K_FETCH : K_MEMCMD;
					end
				end
				ST_RDREQ: st_q <= acc_wr_q ? ST_DEC : ST_RDWT;
				ST_RDWT: st_q <= ST_RDGOT;
				ST_RDGOT: st_q <= ST_DEC;
				ST_DONE: begin
					st_q <= ST_IDLE;
					out_v_q <= 1'b1;
				end
				ST_DEC: begin
					st_q <= ST_RDREQ;
					acc_wr_q <= 1'b0;
					unique case (k_q)
						K_MEMCMD: begin
							if (cmd_q == CMD_WRITE) begin
								acc_wr_q <= 1'b1; acc_a_q <= ad_q; acc_d_q <= wd_q;
								cmd_q <= CMD_NOP; // afterwards done
							end else if (cmd_q == CMD_READ) begin
								acc_a_q <= ad_q; cmd_q <= CMD_EXEC; // read issued
							end else if (cmd_q == CMD_EXEC) begin
								rd_q <= m_rd; st_q <= ST_DONE;
							end else begin
								st_q <= ST_DONE;
							end
						end
						K_FETCH: begin
							acc_a_q <= pc_q; pc_q <= pc_q + 16'd1; k_q <= K_OP;
						end
						K_OP: begin
							op_q <= m_rd;
							k_q <= K_IMM1;
							st_q <= ST_DEC;
							// pre-decode pass: just latch op, decide next cycle
						end
						K_IMM1, K_IMM2, K_DATA, K_DATA2, K_WR2: begin
							// k_q K_IMM1 on entry from K_OP means "op latched, no bytes yet"
							st_q <= ST_DONE;
							if (is_ldrr) begin
								if (op_q[5:3] == 3'd6) begin
									if (k_q == K_IMM1) begin
										acc_wr_q <= 1'b1; acc_a_q <= hl; acc_d_q <= rf_q[r_src];
										k_q <= K_WR2; st_q <= ST_RDREQ;
									end else cyc_q <= 3'd2;
								end else if (op_q[2:0] == 3'd6) begin
									if (k_q == K_IMM1) begin
										acc_a_q <= hl; k_q <= K_DATA; st_q <= ST_RDREQ;
									end else begin
										rf_q[r_dst] <= m_rd; cyc_q <= 3'd2;
									end
								end else begin
									rf_q[r_dst] <= rf_q[r_src]; cyc_q <= 3'd1;
								end
							end else begin
								case (op_q)
									8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h3E: begin
										if (k_q == K_IMM1) begin
											acc_a_q <= pc_q; pc_q <= pc_q + 16'd1;
											k_q <= K_DATA; st_q <= ST_RDREQ;
										end else begin
											rf_q[r_dst] <= m_rd; cyc_q <= 3'd2;
										end
									end
									8'h36: begin
										if (k_q == K_IMM1) begin
											acc_a_q <= pc_q; pc_q <= pc_q + 16'd1;
											k_q <= K_IMM2; st_q <= ST_RDREQ;
										end else if (k_q == K_IMM2) begin
											acc_wr_q <= 1'b1; acc_a_q <= hl; acc_d_q <= m_rd;
											k_q <= K_WR2; st_q <= ST_RDREQ;
										end else cyc_q <= 3'd3;
									end
									8'h01, 8'h11, 8'h21, 8'h31, 8'h08, 8'hEA, 8'hFA: begin
										if (k_q == K_IMM1) begin
											acc_a_q <= pc_q; pc_q <= pc_q + 16'd1;
											k_q <= K_IMM2; st_q <= ST_RDREQ;
										end else if (k_q == K_IMM2) begin
											b1_q <= m_rd;
											acc_a_q <= pc_q; pc_q <= pc_q + 16'd1;
											k_q <= K_DATA; st_q <= ST_RDREQ;
										end else if (k_q == K_DATA) begin
											b2_q <= m_rd; k_q <= K_DATA2; st_q <= ST_DEC;
										end else if (k_q == K_DATA2) begin
											case (op_q)
												8'h01: begin rf_q[IX_B] <= b2_q; rf_q[IX_C] <= b1_q;
													cyc_q <= 3'd3; end
												8'h11: begin rf_q[IX_D] <= b2_q; rf_q[IX_E] <= b1_q;
													cyc_q <= 3'd3; end
												8'h21: begin rf_q[IX_H] <= b2_q; rf_q[IX_L] <= b1_q;
													cyc_q <= 3'd3; end
												8'h31: begin sp_q <= imm16; cyc_q <= 3'd3; end
												8'h08: begin
													acc_wr_q <= 1'b1; acc_a_q <= imm16;
													acc_d_q <= sp_q[7:0]; k_q <= K_WR2;
													b1_q <= 8'h00; st_q <= ST_RDREQ;
												end
												8'hEA: begin
													acc_wr_q <= 1'b1; acc_a_q <= imm16;
													acc_d_q <= rf_q[IX_A]; k_q <= K_WR2;
													b1_q <= 8'h01; st_q <= ST_RDREQ;
												end
												default: begin // FA
													acc_a_q <= imm16; k_q <= K_WR2;
													b1_q <= 8'h02; st_q <= ST_RDREQ;
												end
											endcase
										end else begin // K_WR2
											if (b1_q == 8'h00) begin
												acc_wr_q <= 1'b1; acc_a_q <= acc_a_q + 16'd1;
												acc_d_q <= sp_q[15:8]; b1_q <= 8'h03;
												st_q <= ST_RDREQ;
											end else if (b1_q == 8'h03) cyc_q <= 3'd5;
											else if (b1_q == 8'h01) cyc_q <= 3'd4;
											else begin rf_q[IX_A] <= m_rd; cyc_q <= 3'd4; end
										end
									end
									8'hF9: begin sp_q <= hl; cyc_q <= 3'd2; end
									8'hF8: begin
										if (k_q == K_IMM1) begin
											acc_a_q <= pc_q; pc_q <= pc_q + 16'd1;
											k_q <= K_IMM2; st_q <= ST_RDREQ;
										end else if (k_q == K_IMM2) begin
											b1_q <= m_rd; k_q <= K_DATA; st_q <= ST_DEC;
										end else begin
											rf_q[IX_F] <= {2'b00, hsum[4], csum[8], rf_q[IX_F][3:0]};
											rf_q[IX_H] <= spe[15:8]; rf_q[IX_L] <= spe[7:0];
											cyc_q <= 3'd3;
										end
									end
									8'h02, 8'h12, 8'h22, 8'h32, 8'hE2: begin
										if (k_q == K_IMM1) begin
											acc_wr_q <= 1'b1; acc_d_q <= rf_q[IX_A];
											acc_a_q <= (op_q == 8'h02) ? bc : (op_q == 8'h12) ? de :
												(op_q == 8'hE2) ? (HIGH_PAGE | {8'h00, rf_q[IX_C]}) : hl;
											k_q <= K_WR2; st_q <= ST_RDREQ;
										end else begin
											if (op_q == 8'h22) {rf_q[IX_H], rf_q[IX_L]} <= hl + 16'd1;
											if (op_q == 8'h32) {rf_q[IX_H], rf_q[IX_L]} <= hl - 16'd1;
											cyc_q <= 3'd2;
										end
									end
									8'h0A, 8'h1A, 8'h2A, 8'h3A, 8'hF2: begin
										if (k_q == K_IMM1) begin
											acc_a_q <= (op_q == 8'h0A) ? bc : (op_q == 8'h1A) ? de :
												(op_q == 8'hF2) ? (HIGH_PAGE | {8'h00, rf_q[IX_C]}) : hl;
											k_q <= K_DATA; st_q <= ST_RDREQ;
										end else begin
											rf_q[IX_A] <= m_rd;
											if (op_q == 8'h2A) {rf_q[IX_H], rf_q[IX_L]} <= hl + 16'd1;
											if (op_q == 8'h3A) {rf_q[IX_H], rf_q[IX_L]} <= hl - 16'd1;
											cyc_q <= 3'd2;
										end
									end
									8'hE0, 8'hF0: begin
										if (k_q == K_IMM1) begin
											acc_a_q <= pc_q; pc_q <= pc_q + 16'd1;
											k_q <= K_IMM2; st_q <= ST_RDREQ;
										end else if (k_q == K_IMM2) begin
											acc_a_q <= HIGH_PAGE | {8'h00, m_rd};
											acc_wr_q <= (op_q == 8'hE0); acc_d_q <= rf_q[IX_A];
											k_q <= K_DATA; st_q <= ST_RDREQ;
										end else begin
											if (op_q == 8'hF0) rf_q[IX_A] <= m_rd;
											cyc_q <= 3'd3;
										end
									end
									8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
										if (k_q == K_IMM1) begin
											acc_wr_q <= 1'b1; acc_a_q <= sp_q - 16'd1;
											acc_d_q <= rf_q[pp_hi]; sp_q <= sp_q - 16'd1;
											k_q <= K_IMM2; st_q <= ST_RDREQ;
										end else if (k_q == K_IMM2) begin
											acc_wr_q <= 1'b1; acc_a_q <= sp_q - 16'd1;
											acc_d_q <= rf_q[pp_lo]; sp_q <= sp_q - 16'd1;
											k_q <= K_DATA; st_q <= ST_RDREQ;
										end else cyc_q <= 3'd3;
									end
									8'hC1, 8'hD1, 8'hE1, 8'hF1: begin
										if (k_q == K_IMM1) begin
											acc_a_q <= sp_q; sp_q <= sp_q + 16'd1;
											k_q <= K_IMM2; st_q <= ST_RDREQ;
										end else if (k_q == K_IMM2) begin
											rf_q[pp_lo] <= (op_q == 8'hF1) ? {m_rd[7:4], 4'h0} : m_rd;
											acc_a_q <= sp_q; sp_q <= sp_q + 16'd1;
											k_q <= K_DATA; st_q <= ST_RDREQ;
										end else begin
											rf_q[pp_hi] <= m_rd; cyc_q <= 3'd3;
										end
									end
									default: err_q <= 1'b1;
								endcase
							end
						end
						default: st_q <= ST_DONE;
					endcase
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (st_q == ST_DONE) begin
			res_q.reg_a <= rf_q[IX_A];
			res_q.reg_f <= rf_q[IX_F];
			res_q.pair_bc <= bc;
			res_q.pair_de <= de;
			res_q.pair_hl <= hl;
			res_q.stack_ptr <= sp_q;
			res_q.prog_ctr <= pc_q;
			res_q.machine_cycles <= cyc_q;
			res_q.read_data <= rd_q;
			res_q.status <= err_q;
		end
	end

endmodule
